>>> src/efgu_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// efgu_pkg
// Shared types and codes of the event flag group unit.
// ---------------------------------------------------------------------------
package efgu_pkg;

    localparam int DEF_NUM_GROUPS  = 16;
    localparam int DEF_NUM_WAITERS = 16;
    localparam int DEF_FLAG_BITS   = 32;
    localparam int ARRIVAL_W       = 16;

    localparam logic [2:0] REQ_CREATE = 3'd0;
    localparam logic [2:0] REQ_SET    = 3'd1;
    localparam logic [2:0] REQ_CLEAR  = 3'd2;
    localparam logic [2:0] REQ_DELETE = 3'd3;
    localparam logic [2:0] REQ_WAIT   = 3'd4;
    localparam logic [2:0] REQ_CANCEL = 3'd5;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_INVAL  = 3'd1;
    localparam logic [2:0] ST_AGAIN  = 3'd2;
    localparam logic [2:0] ST_PEND   = 3'd3;
    localparam logic [2:0] ST_BUSY   = 3'd4;
    localparam logic [2:0] ST_NOSLOT = 3'd5;
    localparam logic [2:0] ST_CTX    = 3'd6;
    localparam logic [2:0] ST_FULL   = 3'd7;

    typedef struct packed {
        logic [2:0]  req_type;
        logic        from_isr;
        logic [3:0]  group_index;
        logic [31:0] bits;
        logic [2:0]  wait_mode;
        logic        may_block;
        logic [7:0]  task_id;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  result_group;
        logic [31:0] matched_bits;
        logic [7:0]  woken_task;
        logic        is_wake;
        logic        last;
    } out_item_t;

endpackage

>>> src/event_flag_group_unit_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// event_flag_group_unit_top
// Event flag groups with a shared table of blocked waiters.
// ---------------------------------------------------------------------------
// Sequencing: create, clear, wait and refused requests give their result without
//   a scan; delete and cancel scan the waiter memory once. A set makes one scan
//   pass per waiter of its group plus one.
// Throughput: one request at a time; the waiter memory read port sets the scan.
// Reset: synchronous on aresetn low; clears group and waiter valid bits, the
//   arrival counter and the output valid flag. Memories hold no reset value.
module event_flag_group_unit_top #(
    parameter int NUM_GROUPS  = efgu_pkg::DEF_NUM_GROUPS,
    parameter int NUM_WAITERS = efgu_pkg::DEF_NUM_WAITERS,
    parameter int FLAG_BITS   = efgu_pkg::DEF_FLAG_BITS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  efgu_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output efgu_pkg::out_item_t m_data
);
    import efgu_pkg::*;

    localparam int GW = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
    localparam int IW = (NUM_WAITERS > 1) ? $clog2(NUM_WAITERS) : 1;
    localparam int CW = $clog2(NUM_WAITERS + 1);
    localparam int FW = FLAG_BITS;
    // waiter entry: task, group, mode, arrival, mask
    localparam int EW = 8 + 4 + 3 + ARRIVAL_W + FW;

    typedef enum logic [2:0] {
        S_IDLE, S_GRD, S_SCAN, S_WAKE, S_RESP
    } state_t;

    function automatic logic [FW-1:0] flag_match(input logic [FW-1:0] f,
                                                  input logic [FW-1:0] mk,
                                                  input logic          all);
        logic [FW-1:0] m;
        m = f & mk;
        if (all && (m != mk)) begin
            m = '0;
        end
        return m;
    endfunction

    state_t                  state_reg, state_next;
    in_item_t                req_reg, req_next;
    logic [GW-1:0]           gsel_reg, gsel_next;
    logic [FW-1:0]           bits_reg, bits_next;
    logic [FW-1:0]           flags_reg, flags_next;
    logic [NUM_GROUPS-1:0]   in_use_reg, in_use_next;
    logic [NUM_WAITERS-1:0]  wvalid_reg, wvalid_next;
    logic [NUM_WAITERS-1:0]  seen_reg, seen_next;
    logic [ARRIVAL_W-1:0]    arrival_reg, arrival_next;
    logic [CW-1:0]           scan_idx_reg, scan_idx_next;
    logic                    rd_vld_reg, rd_vld_next;
    logic [IW-1:0]           rd_idx_reg, rd_idx_next;
    logic                    best_vld_reg, best_vld_next;
    logic [IW-1:0]           best_idx_reg, best_idx_next;
    logic [ARRIVAL_W-1:0]    best_age_reg, best_age_next;
    logic [7:0]              best_task_reg, best_task_next;
    logic [FW-1:0]           best_mask_reg, best_mask_next;
    logic [2:0]              best_mode_reg, best_mode_next;
    logic                    hit_reg, hit_next;
    logic [3:0]              hit_grp_reg, hit_grp_next;
    out_item_t               res_reg, res_next;
    logic                    m_valid_reg;
    out_item_t               m_data_reg;

    logic                    out_load, out_free;
    out_item_t               out_data;

    // memory ports
    logic                    gram_we;
    logic [GW-1:0]           gram_waddr, gram_raddr;
    logic [FW-1:0]           gram_wdata, gram_rdata;
    logic                    wram_we;
    logic [IW-1:0]           wram_waddr;
    logic [EW-1:0]           wram_wdata, wram_rdata;

    // lookups
    logic [GW-1:0]           in_gsel;
    logic                    in_g_ok;
    logic [FW-1:0]           in_bits;
    logic                    in_mode_ok;
    logic                    free_g_found;
    logic [GW-1:0]           free_g_idx;
    logic                    free_w_found;
    logic [IW-1:0]           free_w_idx;
    logic [FW-1:0]           wait_m, wake_m;

    // fields of the waiter entry coming back from memory
    logic [FW-1:0]           e_mask;
    logic [ARRIVAL_W-1:0]    e_arr, e_age;
    logic [2:0]              e_mode;
    logic [3:0]              e_grp;
    logic [7:0]              e_task;

    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign out_free = !m_valid_reg || m_ready;

    assign in_gsel    = GW'(s_data.group_index);
    assign in_g_ok    = (32'(s_data.group_index) < NUM_GROUPS) && in_use_reg[in_gsel];
    assign in_bits    = FW'(s_data.bits);
    assign in_mode_ok = (s_data.wait_mode[1:0] == 2'b01) || (s_data.wait_mode[1:0] == 2'b10);

    assign e_mask = wram_rdata[FW-1:0];
    assign e_arr  = wram_rdata[FW +: ARRIVAL_W];
    assign e_mode = wram_rdata[FW + ARRIVAL_W +: 3];
    assign e_grp  = wram_rdata[FW + ARRIVAL_W + 3 +: 4];
    assign e_task = wram_rdata[FW + ARRIVAL_W + 7 +: 8];
    assign e_age  = arrival_reg - e_arr;

    assign wait_m = flag_match(gram_rdata, bits_reg, req_reg.wait_mode[0]);
    assign wake_m = flag_match(flags_reg, best_mask_reg, best_mode_reg[0]);

    // lowest free group and lowest free waiter slot
    always_comb begin
        free_g_found = 1'b0;
        free_g_idx   = '0;
        for (int i = NUM_GROUPS - 1; i >= 0; i--) begin
            if (!in_use_reg[i]) begin
                free_g_found = 1'b1;
                free_g_idx   = GW'(i);
            end
        end
    end

    always_comb begin
        free_w_found = 1'b0;
        free_w_idx   = '0;
        for (int i = NUM_WAITERS - 1; i >= 0; i--) begin
            if (!wvalid_reg[i]) begin
                free_w_found = 1'b1;
                free_w_idx   = IW'(i);
            end
        end
    end

    // Read the group flags at the incoming index while idle, else at the held
    // index. Each request runs alone, so a write always lands before the next
    // read of the same entry.
    assign gram_raddr = (state_reg == S_IDLE) ? in_gsel : gsel_reg;

    assign wram_waddr = free_w_idx;
    assign wram_wdata = {req_reg.task_id, req_reg.group_index, req_reg.wait_mode,
                         arrival_reg, bits_reg};

    always_comb begin
        state_next     = state_reg;
        req_next       = req_reg;
        gsel_next      = gsel_reg;
        bits_next      = bits_reg;
        flags_next     = flags_reg;
        in_use_next    = in_use_reg;
        wvalid_next    = wvalid_reg;
        seen_next      = seen_reg;
        arrival_next   = arrival_reg;
        scan_idx_next  = scan_idx_reg;
        rd_vld_next    = 1'b0;
        rd_idx_next    = rd_idx_reg;
        best_vld_next  = best_vld_reg;
        best_idx_next  = best_idx_reg;
        best_age_next  = best_age_reg;
        best_task_next = best_task_reg;
        best_mask_next = best_mask_reg;
        best_mode_next = best_mode_reg;
        hit_next       = hit_reg;
        hit_grp_next   = hit_grp_reg;
        res_next       = res_reg;
        out_load       = 1'b0;
        out_data       = res_reg;
        gram_we        = 1'b0;
        gram_waddr     = gsel_reg;
        gram_wdata     = '0;
        wram_we        = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    req_next              = s_data;
                    gsel_next             = in_gsel;
                    bits_next             = in_bits;
                    hit_next              = 1'b0;
                    hit_grp_next          = '0;
                    res_next.status       = ST_OK;
                    res_next.result_group = s_data.group_index;
                    res_next.matched_bits = '0;
                    res_next.woken_task   = '0;
                    res_next.is_wake      = 1'b0;
                    res_next.last         = 1'b1;
                    state_next            = S_RESP;
                    if (s_data.from_isr) begin
                        res_next.status       = ST_CTX;
                        res_next.result_group = '0;
                    end else begin
                        case (s_data.req_type)
                            REQ_CREATE: begin
                                if (free_g_found) begin
                                    in_use_next[free_g_idx] = 1'b1;
                                    gram_we                 = 1'b1;
                                    gram_waddr              = free_g_idx;
                                    res_next.result_group   = 4'(free_g_idx);
                                end else begin
                                    res_next.status       = ST_NOSLOT;
                                    res_next.result_group = '0;
                                end
                            end
                            REQ_SET, REQ_CLEAR: begin
                                if (in_g_ok) state_next = S_GRD;
                                else res_next.status = ST_INVAL;
                            end
                            REQ_WAIT: begin
                                if (in_bits != '0 && in_mode_ok && in_g_ok) begin
                                    state_next = S_GRD;
                                end else begin
                                    res_next.status = ST_INVAL;
                                end
                            end
                            REQ_DELETE, REQ_CANCEL: begin
                                if (s_data.req_type == REQ_CANCEL || in_g_ok) begin
                                    scan_idx_next = '0;
                                    best_vld_next = 1'b0;
                                    seen_next     = '0;
                                    state_next    = S_SCAN;
                                end else begin
                                    res_next.status = ST_INVAL;
                                end
                            end
                            default: res_next.status = ST_INVAL;
                        endcase
                    end
                end
            end

            S_GRD: begin
                state_next = S_RESP;
                case (req_reg.req_type)
                    REQ_CLEAR: begin
                        gram_we    = 1'b1;
                        gram_wdata = gram_rdata & ~bits_reg;
                    end
                    REQ_WAIT: begin
                        if (wait_m != '0) begin
                            if (req_reg.wait_mode[2]) begin
                                gram_we    = 1'b1;
                                gram_wdata = gram_rdata & ~wait_m;
                            end
                            res_next.matched_bits = 32'(wait_m);
                        end else if (!req_reg.may_block) begin
                            res_next.status = ST_AGAIN;
                        end else if (free_w_found) begin
                            wram_we                 = 1'b1;
                            wvalid_next[free_w_idx] = 1'b1;
                            arrival_next            = arrival_reg + 1'b1;
                            res_next.status         = ST_PEND;
                        end else begin
                            res_next.status = ST_FULL;
                        end
                    end
                    default: begin
                        // set: merge new flags, then walk the waiters
                        flags_next    = gram_rdata | bits_reg;
                        scan_idx_next = '0;
                        best_vld_next = 1'b0;
                        seen_next     = '0;
                        state_next    = S_SCAN;
                    end
                endcase
            end

            S_SCAN: begin
                if (scan_idx_reg < CW'(NUM_WAITERS)) begin
                    rd_vld_next   = 1'b1;
                    rd_idx_next   = scan_idx_reg[IW-1:0];
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
                if (rd_vld_reg && wvalid_reg[rd_idx_reg]) begin
                    case (req_reg.req_type)
                        REQ_DELETE: begin
                            if (e_grp == req_reg.group_index) hit_next = 1'b1;
                        end
                        REQ_CANCEL: begin
                            if (e_task == req_reg.task_id) begin
                                wvalid_next[rd_idx_reg] = 1'b0;
                                if (!hit_reg) begin
                                    hit_next     = 1'b1;
                                    hit_grp_next = e_grp;
                                end
                            end
                        end
                        default: begin
                            // keep the oldest unseen waiter; ties go to the lower slot
                            if (!seen_reg[rd_idx_reg] && e_grp == req_reg.group_index &&
                                (!best_vld_reg || e_age > best_age_reg)) begin
                                best_vld_next  = 1'b1;
                                best_idx_next  = rd_idx_reg;
                                best_age_next  = e_age;
                                best_task_next = e_task;
                                best_mask_next = e_mask;
                                best_mode_next = e_mode;
                            end
                        end
                    endcase
                end
                if (scan_idx_reg == CW'(NUM_WAITERS) && !rd_vld_reg) begin
                    state_next = S_RESP;
                    case (req_reg.req_type)
                        REQ_DELETE: begin
                            if (hit_reg) res_next.status = ST_BUSY;
                            else in_use_next[gsel_reg] = 1'b0;
                        end
                        REQ_CANCEL: begin
                            res_next.result_group = hit_reg ? hit_grp_reg : 4'd0;
                            res_next.status       = hit_reg ? ST_OK : ST_INVAL;
                        end
                        default: begin
                            if (best_vld_reg) begin
                                state_next = S_WAKE;
                            end else begin
                                gram_we    = 1'b1;
                                gram_wdata = flags_reg;
                            end
                        end
                    endcase
                end
            end

            S_WAKE: begin
                if (wake_m == '0 || out_free) begin
                    seen_next[best_idx_reg] = 1'b1;
                    scan_idx_next           = '0;
                    best_vld_next           = 1'b0;
                    state_next              = S_SCAN;
                end
                if (wake_m != '0 && out_free) begin
                    out_load              = 1'b1;
                    out_data.status       = ST_OK;
                    out_data.result_group = req_reg.group_index;
                    out_data.matched_bits = 32'(wake_m);
                    out_data.woken_task   = best_task_reg;
                    out_data.is_wake      = 1'b1;
                    out_data.last         = 1'b0;
                    wvalid_next[best_idx_reg] = 1'b0;
                    if (best_mode_reg[2]) flags_next = flags_reg & ~wake_m;
                end
            end

            S_RESP: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            in_use_reg   <= '0;
            wvalid_reg   <= '0;
            seen_reg     <= '0;
            arrival_reg  <= '0;
            scan_idx_reg <= '0;
            rd_vld_reg   <= 1'b0;
            best_vld_reg <= 1'b0;
            hit_reg      <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            in_use_reg   <= in_use_next;
            wvalid_reg   <= wvalid_next;
            seen_reg     <= seen_next;
            arrival_reg  <= arrival_next;
            scan_idx_reg <= scan_idx_next;
            rd_vld_reg   <= rd_vld_next;
            best_vld_reg <= best_vld_next;
            hit_reg      <= hit_next;
            // hold the result until the transfer, then drop valid
            if (out_load) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg        <= req_next;
        gsel_reg       <= gsel_next;
        bits_reg       <= bits_next;
        flags_reg      <= flags_next;
        rd_idx_reg     <= rd_idx_next;
        best_idx_reg   <= best_idx_next;
        best_age_reg   <= best_age_next;
        best_task_reg  <= best_task_next;
        best_mask_reg  <= best_mask_next;
        best_mode_reg  <= best_mode_next;
        hit_grp_reg    <= hit_grp_next;
        res_reg        <= res_next;
        if (out_load) m_data_reg <= out_data;
    end

    // group flags, one entry per group
    efgu_ram #(.WIDTH(FW), .DEPTH(NUM_GROUPS)) u_group_ram (
        .aclk  (aclk),
        .we    (gram_we),
        .waddr (gram_waddr),
        .wdata (gram_wdata),
        .raddr (gram_raddr),
        .rdata (gram_rdata)
    );

    // waiter table; slot valid bits live in flops beside it
    efgu_ram #(.WIDTH(EW), .DEPTH(NUM_WAITERS)) u_waiter_ram (
        .aclk  (aclk),
        .we    (wram_we),
        .waddr (wram_waddr),
        .wdata (wram_wdata),
        .raddr (scan_idx_reg[IW-1:0]),
        .rdata (wram_rdata)
    );

endmodule

>>> src/efgu_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// efgu_ram
// Simple dual-port memory, one write and one registered read per cycle.
// ---------------------------------------------------------------------------
module efgu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> src/efgu_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// efgu_checker
// Port-level checks of the event flag group unit.
// ---------------------------------------------------------------------------
module efgu_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input efgu_pkg::out_item_t m_data
);
    import efgu_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_wake_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.is_wake |-> !m_data.last)
        else $error("wake notice marked last");

    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.is_wake |-> m_data.last)
        else $error("final status not marked last");

    a_wake_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.is_wake |-> m_data.status == ST_OK && m_data.matched_bits != '0)
        else $error("wake notice without match");

endmodule

bind event_flag_group_unit_top efgu_checker u_efgu_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

>>> test/event_flag_group_unit_top_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// event_flag_group_unit_top_tb
// Self-checking bench for the event flag group unit.
// ---------------------------------------------------------------------------
// Requests are pushed through the input channel with random gaps. A behavioral
// model of the groups and the waiter table predicts every result. Results are
// pulled with random stalls and compared field by field. One long receiver
// hold-off lets the block back up and stall its input.
// ---------------------------------------------------------------------------
module event_flag_group_unit_top_tb;

    import efgu_pkg::*;

    localparam int NG = 16;
    localparam int NW = 16;
    localparam int N_RANDOM = 230;
    localparam int CYCLE_LIMIT = 2000000;

    // Behavioral model of the group pool and waiter table.
    class flag_group_scoreboard;
        logic [31:0] flags [NG];
        bit          in_use [NG];
        bit          w_valid [NW];
        logic [7:0]  w_task [NW];
        logic [3:0]  w_group [NW];
        logic [31:0] w_mask [NW];
        logic [2:0]  w_mode [NW];
        logic [15:0] w_arrival [NW];
        logic [15:0] arrival_cnt;
        out_item_t   pending_results [$];
        int          errors;
        int          checked;
        int          wakes;

        function new();
            for (int i = 0; i < NG; i++) begin
                flags[i] = '0;
                in_use[i] = 0;
            end
            for (int i = 0; i < NW; i++) w_valid[i] = 0;
            arrival_cnt = '0;
            errors = 0;
            checked = 0;
            wakes = 0;
        endfunction

        function void push(logic [2:0] st, logic [3:0] grp, logic [31:0] m,
                           logic [7:0] tsk, bit wake, bit lst);
            out_item_t r;
            r.status = st;
            r.result_group = grp;
            r.matched_bits = m;
            r.woken_task = tsk;
            r.is_wake = wake;
            r.last = lst;
            pending_results.push_back(r);
        endfunction

        function logic [31:0] match_flags(logic [31:0] fl, logic [31:0] mask,
                                          logic [2:0] mode);
            logic [31:0] m;
            m = fl & mask;
            if (mode[0]) return (m == mask) ? m : '0;
            return m;
        endfunction

        function bit group_live(logic [3:0] g);
            return in_use[g];
        endfunction

        // Note an accepted request and queue the results it causes.
        function void note_request(in_item_t rq);
            bit seen [NW];
            int best;
            logic [15:0] best_age, age;
            logic [31:0] m;
            int slot;
            bit found;
            if (rq.from_isr) begin
                push(ST_CTX, 0, 0, 0, 0, 1);
                return;
            end
            case (rq.req_type)
                REQ_CREATE: begin
                    found = 0;
                    for (int i = 0; i < NG && !found; i++) begin
                        if (!in_use[i]) begin
                            in_use[i] = 1;
                            flags[i] = '0;
                            push(ST_OK, 4'(i), 0, 0, 0, 1);
                            found = 1;
                        end
                    end
                    if (!found) push(ST_NOSLOT, 0, 0, 0, 0, 1);
                end
                REQ_SET: begin
                    if (!group_live(rq.group_index)) begin
                        push(ST_INVAL, rq.group_index, 0, 0, 0, 1);
                        return;
                    end
                    for (int i = 0; i < NW; i++) seen[i] = 0;
                    flags[rq.group_index] |= rq.bits;
                    forever begin
                        best = -1;
                        best_age = '0;
                        for (int i = 0; i < NW; i++) begin
                            if (w_valid[i] && !seen[i] && w_group[i] == rq.group_index) begin
                                age = arrival_cnt - w_arrival[i];
                                if (best < 0 || age > best_age) begin
                                    best = i;
                                    best_age = age;
                                end
                            end
                        end
                        if (best < 0) break;
                        seen[best] = 1;
                        m = match_flags(flags[rq.group_index], w_mask[best], w_mode[best]);
                        if (m != 0) begin
                            if (w_mode[best][2]) flags[rq.group_index] &= ~m;
                            w_valid[best] = 0;
                            push(ST_OK, rq.group_index, m, w_task[best], 1, 0);
                            wakes++;
                        end
                    end
                    push(ST_OK, rq.group_index, 0, 0, 0, 1);
                end
                REQ_CLEAR: begin
                    if (!group_live(rq.group_index)) begin
                        push(ST_INVAL, rq.group_index, 0, 0, 0, 1);
                        return;
                    end
                    flags[rq.group_index] &= ~rq.bits;
                    push(ST_OK, rq.group_index, 0, 0, 0, 1);
                end
                REQ_DELETE: begin
                    if (!group_live(rq.group_index)) begin
                        push(ST_INVAL, rq.group_index, 0, 0, 0, 1);
                        return;
                    end
                    found = 0;
                    for (int i = 0; i < NW; i++)
                        if (w_valid[i] && w_group[i] == rq.group_index) found = 1;
                    if (found) begin
                        push(ST_BUSY, rq.group_index, 0, 0, 0, 1);
                    end else begin
                        in_use[rq.group_index] = 0;
                        flags[rq.group_index] = '0;
                        push(ST_OK, rq.group_index, 0, 0, 0, 1);
                    end
                end
                REQ_WAIT: begin
                    if (rq.bits == 0 || (rq.wait_mode[1:0] != 2'd1 && rq.wait_mode[1:0] != 2'd2)
                            || !group_live(rq.group_index)) begin
                        push(ST_INVAL, rq.group_index, 0, 0, 0, 1);
                        return;
                    end
                    m = match_flags(flags[rq.group_index], rq.bits, rq.wait_mode);
                    if (m != 0) begin
                        if (rq.wait_mode[2]) flags[rq.group_index] &= ~m;
                        push(ST_OK, rq.group_index, m, 0, 0, 1);
                        return;
                    end
                    if (!rq.may_block) begin
                        push(ST_AGAIN, rq.group_index, 0, 0, 0, 1);
                        return;
                    end
                    slot = -1;
                    for (int i = NW - 1; i >= 0; i--) if (!w_valid[i]) slot = i;
                    if (slot < 0) begin
                        push(ST_FULL, rq.group_index, 0, 0, 0, 1);
                        return;
                    end
                    w_valid[slot] = 1;
                    w_task[slot] = rq.task_id;
                    w_group[slot] = rq.group_index;
                    w_mask[slot] = rq.bits;
                    w_mode[slot] = rq.wait_mode;
                    w_arrival[slot] = arrival_cnt;
                    arrival_cnt++;
                    push(ST_PEND, rq.group_index, 0, 0, 0, 1);
                end
                REQ_CANCEL: begin
                    slot = -1;
                    for (int i = 0; i < NW; i++) begin
                        if (w_valid[i] && w_task[i] == rq.task_id) begin
                            if (slot < 0) slot = i;
                            w_valid[i] = 0;
                        end
                    end
                    if (slot < 0) push(ST_INVAL, 0, 0, 0, 0, 1);
                    else push(ST_OK, w_group[slot], 0, 0, 0, 1);
                end
                default: push(ST_INVAL, rq.group_index, 0, 0, 0, 1);
            endcase
        endfunction

        // Compare one accepted result with the oldest expectation.
        function void check_result(out_item_t got);
            out_item_t exp_r;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            exp_r = pending_results.pop_front();
            checked++;
            if (got.status !== exp_r.status)
                $display("%0t: status exp %0d got %0d", $time, exp_r.status, got.status);
            if (got.result_group !== exp_r.result_group)
                $display("%0t: result_group exp %0d got %0d", $time,
                         exp_r.result_group, got.result_group);
            if (got.matched_bits !== exp_r.matched_bits)
                $display("%0t: matched_bits exp %h got %h", $time,
                         exp_r.matched_bits, got.matched_bits);
            if (got.woken_task !== exp_r.woken_task)
                $display("%0t: woken_task exp %0d got %0d", $time,
                         exp_r.woken_task, got.woken_task);
            if (got.is_wake !== exp_r.is_wake)
                $display("%0t: is_wake exp %0d got %0d", $time, exp_r.is_wake, got.is_wake);
            if (got.last !== exp_r.last)
                $display("%0t: last exp %0d got %0d", $time, exp_r.last, got.last);
            if (got !== exp_r) errors++;
        endfunction
    endclass

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;

    flag_group_scoreboard sb;
    bit  hold_off;
    bit  stim_done;
    int  cycles;
    int  accepted;

    event_flag_group_unit_top u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // Note every input transfer and check every output transfer.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.note_request(s_data);
                accepted++;
            end
            if (m_valid && m_ready) sb.check_result(m_data);
        end
    end

    // Hard limit on run length.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin
        m_ready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            int gap;
            if (hold_off) begin
                m_ready <= 1'b0;
                repeat (600) @(posedge aclk);
                hold_off = 0;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    // Offer one request and hold it until transferred; drop valid only
    // across an idle gap so back-to-back offers keep valid high.
    task automatic send_request(in_item_t rq, bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 16);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= rq;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    function automatic in_item_t make_req(logic [2:0] rt, logic [3:0] g, logic [31:0] b,
                                          logic [2:0] mode, bit blk, logic [7:0] tsk);
        in_item_t rq;
        rq.req_type = rt;
        rq.from_isr = 1'b0;
        rq.group_index = g;
        rq.bits = b;
        rq.wait_mode = mode;
        rq.may_block = blk;
        rq.task_id = tsk;
        return rq;
    endfunction

    // Random request, biased toward live groups and well-formed waits.
    function automatic in_item_t random_req();
        in_item_t rq;
        int pick;
        pick = $urandom_range(0, 99);
        rq = make_req(REQ_WAIT, 4'($urandom_range(0, 5)), $urandom, 3'($urandom_range(0, 7)),
                      1'($urandom_range(0, 1)), 8'($urandom_range(0, 11)));
        if ($urandom_range(0, 3) != 0) rq.bits = 32'(1) << $urandom_range(0, 31);
        if ($urandom_range(0, 3) == 0) rq.bits |= $urandom;
        if (pick < 8) rq.req_type = REQ_CREATE;
        else if (pick < 35) rq.req_type = REQ_SET;
        else if (pick < 45) rq.req_type = REQ_CLEAR;
        else if (pick < 51) rq.req_type = REQ_DELETE;
        else if (pick < 85) begin
            rq.req_type = REQ_WAIT;
            rq.wait_mode[1:0] = 2'($urandom_range(1, 2));
            rq.may_block = ($urandom_range(0, 4) != 0);
        end else if (pick < 93) rq.req_type = REQ_CANCEL;
        else if (pick < 96) rq.req_type = 3'($urandom_range(6, 7));
        else begin
            rq.req_type = 3'($urandom_range(0, 7));
            rq.group_index = 4'($urandom);
            rq.task_id = 8'($urandom);
        end
        rq.from_isr = ($urandom_range(0, 29) == 0);
        return rq;
    endfunction

    initial begin
        in_item_t rq;
        int waited;
        sb = new();
        hold_off = 0;
        stim_done = 0;
        cycles = 0;
        accepted = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: refusals, invalid groups, create/wait/set/cancel paths.
        rq = make_req(REQ_SET, 4'hF, 32'hFFFF_FFFF, 3'd7, 1, 8'hFF);
        rq.from_isr = 1'b1;
        send_request(rq, 0);
        send_request(make_req(REQ_SET, 4'd0, 32'h1, 3'd1, 0, 0), 0);
        send_request(make_req(3'd6, 4'd15, 32'h0, 3'd0, 0, 0), 0);
        send_request(make_req(3'd7, 4'd3, 32'h0, 3'd0, 0, 0), 0);
        send_request(make_req(REQ_CANCEL, 4'd0, 32'h0, 3'd0, 0, 8'd200), 0);
        send_request(make_req(REQ_CREATE, 4'd0, 32'h0, 3'd0, 0, 0), 0);
        send_request(make_req(REQ_CREATE, 4'd0, 32'h0, 3'd0, 0, 0), 0);
        send_request(make_req(REQ_WAIT, 4'd0, 32'h0, 3'd1, 1, 1), 0);
        send_request(make_req(REQ_WAIT, 4'd0, 32'h3, 3'd3, 1, 1), 0);
        send_request(make_req(REQ_WAIT, 4'd0, 32'h3, 3'd0, 1, 1), 0);
        send_request(make_req(REQ_WAIT, 4'd0, 32'h3, 3'd1, 0, 1), 0);
        send_request(make_req(REQ_WAIT, 4'd0, 32'h3, 3'd5, 1, 8'd1), 0);
        send_request(make_req(REQ_WAIT, 4'd0, 32'h6, 3'd2, 1, 8'd2), 0);
        send_request(make_req(REQ_WAIT, 4'd0, 32'h8000_0000, 3'd6, 1, 8'd255), 0);
        send_request(make_req(REQ_DELETE, 4'd0, 32'h0, 3'd0, 0, 0), 0);
        send_request(make_req(REQ_SET, 4'd0, 32'hFFFF_FFFF, 3'd0, 0, 0), 0);
        send_request(make_req(REQ_WAIT, 4'd0, 32'hFFFF_FFFF, 3'd1, 0, 0), 0);
        send_request(make_req(REQ_CLEAR, 4'd0, 32'hFFFF_FFFF, 3'd0, 0, 0), 0);
        send_request(make_req(REQ_WAIT, 4'd1, 32'h5, 3'd1, 1, 8'd7), 0);
        send_request(make_req(REQ_CANCEL, 4'd0, 32'h0, 3'd0, 0, 8'd7), 0);
        send_request(make_req(REQ_DELETE, 4'd1, 32'h0, 3'd0, 0, 0), 0);
        for (int i = 0; i < 16; i++)
            send_request(make_req(REQ_CREATE, 4'd0, 32'h0, 3'd0, 0, 0), 1);
        for (int i = 0; i < 17; i++)
            send_request(make_req(REQ_WAIT, 4'd2, 32'(1) << i, 3'd2, 1, 8'(i)), 1);
        send_request(make_req(REQ_SET, 4'd2, 32'h0001_FFFF, 3'd0, 0, 0), 0);

        // Long receiver hold-off while requests keep coming.
        hold_off = 1;
        for (int i = 0; i < 12; i++)
            send_request(make_req(REQ_CLEAR, 4'd3, $urandom, 3'd0, 0, 0), 1);
        for (int i = 3; i < 16; i++)
            send_request(make_req(REQ_DELETE, 4'(i), 32'h0, 3'd0, 0, 0), 0);

        for (int n = 0; n < N_RANDOM; n++) send_request(random_req(), 0);
        s_valid <= 1'b0;
        stim_done = 1;

        waited = 0;
        while (sb.pending_results.size() != 0 && waited < 20000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (400) @(posedge aclk);

        $display("Run covered %0d requests, %0d results checked, %0d wake notices.",
                 accepted, sb.checked, sb.wakes);
        if (sb.errors == 0 && sb.pending_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Mismatches: %0d, results still missing: %0d",
                     sb.errors, sb.pending_results.size());
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
